// ----- design/pbm_pkg.sv -----
// Package for the patch box-mean unit: sizing constants, item and
// configuration types, register indexes.
// Depends on nothing; every other design file imports it.
package pbm_pkg;

	// Sizing
	localparam int MAX_ROWS     = 64;
	localparam int MAX_COLS     = 64;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_PATCH    = 16;
	localparam int SAMPLE_BITS  = 16;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int CH_W   = $clog2(MAX_CHANNELS);
	localparam int ADDR_W = ROW_W + COL_W + CH_W;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;

	// Pixel count of a patch and the per-channel sum of its samples
	localparam int CNT_W = $clog2(MAX_PATCH * MAX_PATCH + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	// Register file
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [2:0] REG_IMAGE_ROWS    = 3'd0;
	localparam logic [2:0] REG_IMAGE_COLS    = 3'd1;
	localparam logic [2:0] REG_PATCH_HEIGHT  = 3'd2;
	localparam logic [2:0] REG_PATCH_WIDTH   = 3'd3;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

	// Item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic [6:0] image_rows;
		logic [6:0] image_cols;
		logic [4:0] patch_height;
		logic [4:0] patch_width;
		logic [2:0] channel_count;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [5:0]  pos_row;
		logic [5:0]  pos_col;
		logic [1:0]  chan;
		logic [15:0] sample_value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  chan_out;
		logic [15:0] mean_value;
		logic        empty_patch;
		logic        last_of_run;
	} rsp_item_t;

endpackage

// ----- design/pbm_regs.sv -----
// Configuration registers of the patch box-mean unit behind an APB-style port.
// Depends on pbm_pkg.
module pbm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbm_pkg::PADDR_W-1:0] paddr,
	input  logic [pbm_pkg::PDATA_W-1:0] pwdata,
	output logic [pbm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output pbm_pkg::cfg_t               cfg
);
	import pbm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_rows    <= 7'd64;
			cfg_q.image_cols    <= 7'd64;
			cfg_q.patch_height  <= 5'd3;
			cfg_q.patch_width   <= 5'd3;
			cfg_q.channel_count <= 3'd3;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_ROWS:    cfg_q.image_rows    <= pwdata[6:0];
				REG_IMAGE_COLS:    cfg_q.image_cols    <= pwdata[6:0];
				REG_PATCH_HEIGHT:  cfg_q.patch_height  <= pwdata[4:0];
				REG_PATCH_WIDTH:   cfg_q.patch_width   <= pwdata[4:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_ROWS:    prdata = {25'd0, cfg_q.image_rows};
			REG_IMAGE_COLS:    prdata = {25'd0, cfg_q.image_cols};
			REG_PATCH_HEIGHT:  prdata = {27'd0, cfg_q.patch_height};
			REG_PATCH_WIDTH:   prdata = {27'd0, cfg_q.patch_width};
			REG_CHANNEL_COUNT: prdata = {29'd0, cfg_q.channel_count};
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- design/pbm_store.sv -----
// Sample store: one write port, one read port with registered read data.
// Depends on pbm_pkg.
module pbm_store (
	input  logic                            clk,
	input  logic                            we,
	input  logic [pbm_pkg::ADDR_W-1:0]      waddr,
	input  logic [pbm_pkg::SAMPLE_BITS-1:0] wdata,
	input  logic [pbm_pkg::ADDR_W-1:0]      raddr,
	output logic [pbm_pkg::SAMPLE_BITS-1:0] rdata
);
	import pbm_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;

	assign rdata = rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

// ----- design/pbm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle: patch sum by pixel count.
// Depends on pbm_pkg.
module pbm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pbm_pkg::SUM_W-1:0]       dividend,
	input  logic [pbm_pkg::CNT_W-1:0]       divisor,
	output logic                            done,
	output logic [pbm_pkg::SAMPLE_BITS-1:0] quotient
);
	import pbm_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_diff;
	logic              fits;

	// One trial subtraction
	assign rem_sh   = {rem_q, dq_q[SUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign fits     = rem_sh >= {1'b0, div_q};

	assign done     = done_q;
	assign quotient = dq_q[SAMPLE_BITS-1:0];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

endmodule

// ----- design/patch_box_mean_unit.sv -----
// Patch box-mean unit: top level with the query sequencer and result register.
// Depends on pbm_pkg, pbm_regs, pbm_store and pbm_div.
//
// Usage. Items arrive on req (valid/ready). A load item writes one 16-bit
// sample into the sample store at (row, column, channel); it gives no result
// and leaves the unit ready for the next item. A query item names a patch's
// top-left corner; the unit walks the in-image part of the patch, reading
// one sample per cycle from the store's read port, then divides each
// channel's sum by the in-image pixel count with a bit-serial divider. One
// result per channel in use leaves on rsp (valid/ready), the last one flagged
// with last_of_run. A patch with no pixel inside the image gives means of 0
// with empty_patch set. Query time is set by the store reads of the in-image
// pixels of every channel in use and by one division per channel.
// Results sit in an output register: a new item is taken as soon as the last
// result of a query is in it; a stalled receiver stalls the sequencer only
// when a further result is ready. Reset clears control state and sets the
// registers to their defaults; the store is not cleared, and a sample must
// be loaded before a query reads it.
module patch_box_mean_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  pbm_pkg::req_item_t          req_item,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output pbm_pkg::rsp_item_t          rsp_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbm_pkg::PADDR_W-1:0] paddr,
	input  logic [pbm_pkg::PDATA_W-1:0] pwdata,
	output logic [pbm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import pbm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DIVS  = 3'd4;
	localparam logic [2:0] ST_DIVW  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	cfg_t cfg;

	logic [2:0] state_q;

	// Query context
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       r_q;
	logic [COL_W-1:0]       c_q;
	logic [CH_W-1:0]        d_q;
	logic [CH_W-1:0]        k_q;
	logic [6:0]             rend_q;
	logic [6:0]             cend_q;
	logic [2:0]             nch_q;
	logic [CNT_W-1:0]       count_q;
	logic                   empty_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [SUM_W-1:0]       sum_q [MAX_CHANNELS];

	// Read pipeline
	logic                   rd_valid_s1;
	logic [CH_W-1:0]        rd_chan_s1;
	logic [SAMPLE_BITS-1:0] rdata;

	// Output register
	logic      rsp_valid_q;
	rsp_item_t rsp_item_q;

	// Extent set-up
	logic [6:0] rows_sat, cols_sat, rend, cend;
	logic [4:0] ph_sat, pw_sat, nr, nc;
	logic [2:0] nch_sat;
	logic [9:0] pix_cnt;

	logic req_fire, div_start, div_done, out_free, last_res;
	logic last_d, last_c, last_r;
	logic [SAMPLE_BITS-1:0] quotient;

	pbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbm_store u_store (
		.clk   (clk),
		.we    (req_fire && req_item.func == FUNC_LOAD),
		.waddr ({req_item.pos_row, req_item.pos_col, req_item.chan}),
		.wdata (req_item.sample_value),
		.raddr ({r_q, c_q, d_q}),
		.rdata (rdata)
	);

	pbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[k_q]),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid & req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign div_start = (state_q == ST_DIVS) && !empty_q;
	assign last_res  = ({1'b0, k_q} + 3'd1) == nch_q;

	// Clip the patch to the image and saturate the registers
	always_comb begin
		rows_sat = (cfg.image_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.image_rows;
		cols_sat = (cfg.image_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.image_cols;
		ph_sat   = (cfg.patch_height > 5'(MAX_PATCH)) ? 5'(MAX_PATCH) : cfg.patch_height;
		pw_sat   = (cfg.patch_width > 5'(MAX_PATCH)) ? 5'(MAX_PATCH) : cfg.patch_width;
		nch_sat  = (cfg.channel_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS)
			: cfg.channel_count;
		rend = 7'(row_q) + 7'(ph_sat);
		if (rend > rows_sat) begin
			rend = rows_sat;
		end
		cend = 7'(col_q) + 7'(pw_sat);
		if (cend > cols_sat) begin
			cend = cols_sat;
		end
		nr = (rend > 7'(row_q)) ? 5'(rend - 7'(row_q)) : 5'd0;
		nc = (cend > 7'(col_q)) ? 5'(cend - 7'(col_q)) : 5'd0;
		pix_cnt = 10'(nr) * 10'(nc);
	end

	// Scan order: channel, then column, then row
	assign last_d = ({1'b0, d_q} + 3'd1) == nch_q;
	assign last_c = (7'(c_q) + 7'd1) == cend_q;
	assign last_r = (7'(r_q) + 7'd1) == rend_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_READ);
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && req_item.func == FUNC_QUERY) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (nch_sat == 3'd0) begin
						state_q <= ST_IDLE;
					end else if (pix_cnt == 10'd0) begin
						state_q <= ST_DIVS;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (last_d && last_c && last_r) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DIVS;
				ST_DIVS: state_q <= empty_q ? ST_OUT : ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= last_res ? ST_IDLE : ST_DIVS;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query datapath
	always_ff @(posedge clk) begin
		rd_chan_s1 <= d_q;
		case (state_q)
			ST_IDLE: begin
				row_q <= req_item.pos_row;
				col_q <= req_item.pos_col;
			end
			ST_SETUP: begin
				r_q     <= row_q;
				c_q     <= col_q;
				d_q     <= '0;
				k_q     <= '0;
				rend_q  <= rend;
				cend_q  <= cend;
				nch_q   <= nch_sat;
				count_q <= CNT_W'(pix_cnt);
				empty_q <= (pix_cnt == 10'd0);
			end
			ST_READ: begin
				if (!last_d) begin
					d_q <= d_q + 1'b1;
				end else begin
					d_q <= '0;
					if (!last_c) begin
						c_q <= c_q + 1'b1;
					end else begin
						c_q <= col_q;
						r_q <= r_q + 1'b1;
					end
				end
			end
			ST_DIVS: begin
				if (empty_q) begin
					mean_q <= '0;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					mean_q <= quotient;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_item_q.chan_out    <= k_q;
					rsp_item_q.mean_value  <= mean_q;
					rsp_item_q.empty_patch <= empty_q;
					rsp_item_q.last_of_run <= last_res;
					k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Per-channel accumulators, one lane each
	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_acc
		always_ff @(posedge clk) begin
			if (state_q == ST_SETUP) begin
				sum_q[g] <= '0;
			end else if (rd_valid_s1 && rd_chan_s1 == CH_W'(g)) begin
				sum_q[g] <= sum_q[g] + SUM_W'(rdata);
			end
		end
	end

endmodule
